// ===== rtl/bpa_pkg.sv =====
// Shared types and constants of the buddy page allocator.
// No dependencies.
package bpa_pkg;

  localparam int unsigned MaxOrderDef = 10;
  localparam logic [31:0] BasePageRst = 32'h8000_0000 >> 12;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_ORDER  = 3'd1,
    ST_NOMEM  = 3'd2,
    ST_DOUBLE = 3'd3,
    ST_RANGE  = 3'd4
  } status_t;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // one entry per page
  typedef struct packed {
    logic       in_use;
    logic       free_head;
    logic [3:0] order;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

// ===== rtl/bpa_if.sv =====
// Handshake channels of the buddy page allocator: request, result, config.
// Depends on nothing.
interface bpa_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [3:0]  req_order;
  logic [31:0] page_number;
  modport source (output valid, req_type, req_order, page_number, input ready);
  modport sink   (input valid, req_type, req_order, page_number, output ready);
endinterface

interface bpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] page_out;
  logic [3:0]  block_order;
  modport source (output valid, status, page_out, block_order, input ready);
  modport sink   (input valid, status, page_out, block_order, output ready);
endinterface

interface bpa_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] mem_base_page;
  modport source (output valid, mem_base_page, input ready);
  modport sink   (input valid, mem_base_page, output ready);
endinterface

// ===== rtl/bpa_ram.sv =====
// Generic simple dual-port RAM, one write and one read port, registered read.
// No dependencies.
module bpa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/buddy_page_allocator.sv =====
// Buddy page allocator top level: control sequencer around the page table RAM.
// Depends on bpa_pkg, bpa_if.sv and bpa_ram.
//
// Usage
//   in_ch  : requests. req_type allocate (order req_order) or free (page_number).
//   out_ch : one result per request: status, page_out, block_order.
//   cfg_ch : writes mem_base_page; always ready, write only while idle.
//   One request is handled at a time; in_ch is ready when the sequencer is idle
//   and the result register is empty.
// Sequence
//   Allocate: the page table is scanned one entry per cycle through the RAM
//   read port, then the block found is split one level at a time.
//   Free: the entry is read, then each merge level is a RAM read then a check,
//   up to MAX_ORDER. A double free is reported from the first read of the entry.
//   Errors found at acceptance give a result the next cycle.
// Reset
//   A clearing pass writes each of the NPAGES entries (1024 by default) as an
//   allocated order-0 page; no request is taken meanwhile.
// Stall
//   A result waits in the output register until transferred; no new request
//   is taken until then.
module buddy_page_allocator #(
  parameter int unsigned MAX_ORDER = bpa_pkg::MaxOrderDef
) (
  input logic       clk,
  input logic       rst_n,
  bpa_req_if.sink   in_ch,
  bpa_rsp_if.source out_ch,
  bpa_cfg_if.sink   cfg_ch
);
  import bpa_pkg::*;

  localparam int unsigned AW = MAX_ORDER;
  localparam int unsigned NPages = 1 << MAX_ORDER;
  localparam logic [3:0] MaxOrd = 4'(MAX_ORDER);

  typedef enum logic [6:0] {
    S_CLR   = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_SPLIT = 7'b0001000,
    S_FRD   = 7'b0010000,
    S_MERGE = 7'b0100000,
    S_BCHK  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [31:0] base_r, base_nxt;
  logic [AW:0] cnt_r, cnt_nxt;
  logic [AW-1:0] chk_r, chk_nxt;
  logic dv_r, dv_nxt;
  logic found_r, found_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [3:0] ord_r, ord_nxt;
  logic [3:0] want_r, want_nxt;
  logic [AW-1:0] bud_r, bud_nxt;
  logic ov_r, ov_nxt;
  logic [2:0] ost_r, ost_nxt;
  logic [31:0] opg_r, opg_nxt;
  logic [3:0] oord_r, oord_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  entry_t wdata, rdata;
  logic [EntryW-1:0] rdata_raw;
  logic [31:0] rel;
  logic [AW-1:0] half;

  bpa_ram #(.Width(EntryW), .Depth(NPages)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata_raw)
  );
  assign rdata = entry_t'(rdata_raw);

  assign in_ch.ready = (state_r == S_IDLE) && !ov_r;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = ov_r;
  assign out_ch.status = ost_r;
  assign out_ch.page_out = opg_r;
  assign out_ch.block_order = oord_r;

  assign rel = in_ch.page_number - base_r;
  assign half = AW'(1) << ord_r;

  always_comb begin
    state_nxt = state_r;
    base_nxt = base_r;
    cnt_nxt = cnt_r;
    chk_nxt = chk_r;
    dv_nxt = 1'b0;
    found_nxt = found_r;
    idx_nxt = idx_r;
    ord_nxt = ord_r;
    want_nxt = want_r;
    bud_nxt = bud_r;
    ov_nxt = ov_r;
    ost_nxt = ost_r;
    opg_nxt = opg_r;
    oord_nxt = oord_r;
    we = 1'b0;
    waddr = idx_r;
    wdata = '{in_use: 1'b1, free_head: 1'b0, order: 4'd0};
    raddr = idx_r;

    if (cfg_ch.valid) base_nxt = cfg_ch.mem_base_page;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;

    case (state_r)
      S_CLR: begin
        we = 1'b1;
        waddr = cnt_r[AW-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[AW-1:0] == AW'(NPages - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          if (in_ch.req_type == REQ_ALLOC) begin
            want_nxt = in_ch.req_order;
            if (in_ch.req_order > MaxOrd) begin
              ov_nxt = 1'b1; ost_nxt = ST_ORDER; opg_nxt = '0; oord_nxt = '0;
            end else begin
              cnt_nxt = '0;
              found_nxt = 1'b0;
              state_nxt = S_SCAN;
            end
          end else if (rel >= 32'(NPages)) begin
            ov_nxt = 1'b1; ost_nxt = ST_RANGE; opg_nxt = '0; oord_nxt = '0;
          end else begin
            idx_nxt = rel[AW-1:0];
            raddr = rel[AW-1:0];
            state_nxt = S_FRD;
          end
        end
      end
      S_SCAN: begin
        raddr = cnt_r[AW-1:0];
        if (!cnt_r[AW]) begin
          cnt_nxt = cnt_r + 1'b1;
          dv_nxt = 1'b1;
          chk_nxt = cnt_r[AW-1:0];
        end
        if (dv_r && rdata.free_head && rdata.order >= want_r &&
            (!found_r || rdata.order < ord_r)) begin
          found_nxt = 1'b1;
          idx_nxt = chk_r;
          ord_nxt = rdata.order;
        end
        if (cnt_r[AW] && !dv_r) begin
          if (found_r) state_nxt = S_SPLIT;
          else begin
            ov_nxt = 1'b1; ost_nxt = ST_NOMEM; opg_nxt = '0; oord_nxt = '0;
            state_nxt = S_IDLE;
          end
        end
      end
      S_SPLIT: begin
        we = 1'b1;
        if (ord_r > want_r) begin
          // lower half stays free, carry on with the upper half
          wdata = '{in_use: 1'b0, free_head: 1'b1, order: ord_r - 4'd1};
          idx_nxt = idx_r + (AW'(1) << (ord_r - 4'd1));
          ord_nxt = ord_r - 4'd1;
        end else begin
          wdata = '{in_use: 1'b1, free_head: 1'b0, order: want_r};
          ov_nxt = 1'b1; ost_nxt = ST_OK;
          opg_nxt = base_r + 32'(idx_r);
          oord_nxt = want_r;
          state_nxt = S_IDLE;
        end
      end
      S_FRD: begin
        if (!rdata.in_use) begin
          ov_nxt = 1'b1; ost_nxt = ST_DOUBLE; opg_nxt = '0; oord_nxt = '0;
          state_nxt = S_IDLE;
        end else begin
          ord_nxt = rdata.order;
          state_nxt = S_MERGE;
        end
      end
      S_MERGE: begin
        if (ord_r < MaxOrd) begin
          bud_nxt = idx_r ^ half;
          raddr = idx_r ^ half;
          state_nxt = S_BCHK;
        end else begin
          we = 1'b1;
          wdata = '{in_use: 1'b0, free_head: 1'b1, order: ord_r};
          ov_nxt = 1'b1; ost_nxt = ST_OK;
          opg_nxt = base_r + 32'(idx_r);
          oord_nxt = ord_r;
          state_nxt = S_IDLE;
        end
      end
      S_BCHK: begin
        we = 1'b1;
        if (rdata.free_head && rdata.order == ord_r) begin
          // upper block is absorbed into the lower one
          waddr = (bud_r > idx_r) ? bud_r : idx_r;
          wdata = '{in_use: 1'b0, free_head: 1'b0, order: 4'd0};
          idx_nxt = (bud_r < idx_r) ? bud_r : idx_r;
          ord_nxt = ord_r + 4'd1;
          state_nxt = S_MERGE;
        end else begin
          wdata = '{in_use: 1'b0, free_head: 1'b1, order: ord_r};
          ov_nxt = 1'b1; ost_nxt = ST_OK;
          opg_nxt = base_r + 32'(idx_r);
          oord_nxt = ord_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      base_r <= BasePageRst;
      cnt_r <= '0;
      dv_r <= 1'b0;
      found_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      base_r <= base_nxt;
      cnt_r <= cnt_nxt;
      dv_r <= dv_nxt;
      found_r <= found_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r <= chk_nxt;
    idx_r <= idx_nxt;
    ord_r <= ord_nxt;
    want_r <= want_nxt;
    bud_r <= bud_nxt;
    ost_r <= ost_nxt;
    opg_r <= opg_nxt;
    oord_r <= oord_nxt;
  end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for buddy_page_allocator: directed table, pool fill, then random
// alloc/free traffic under several idling phases, checked against a page-table predictor.
// Depends on bpa_pkg and the channel interfaces in rtl/bpa_if.sv.
module testbench;
  import bpa_pkg::*;

  localparam int unsigned NPages = 1 << MaxOrderDef;
  localparam int unsigned LimitCycles = 8000000;

  typedef struct {
    logic        rtype;
    logic [3:0]  ord;
    logic [31:0] page;
    logic        fixed;
    status_t     x_st;
    logic [31:0] x_page;
    logic [3:0]  x_ord;
  } row_t;

  typedef struct {
    status_t     st;
    logic [31:0] page;
    logic [3:0]  ord;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bpa_req_if in_ch ();
  bpa_rsp_if out_ch ();
  bpa_cfg_if cfg_ch ();

  buddy_page_allocator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic        pg_used [NPages];
  logic        pg_head [NPages];
  logic [3:0]  pg_ord  [NPages];
  logic [31:0] base_page;
  rsp_t        pending_rsp [$];
  row_t        dir_rows [$];

  int errors = 0;
  int n_sent = 0, n_got = 0, n_ok = 0, n_err = 0;
  int cycles = 0;
  int send_idle = 0, recv_stall = 0;
  bit hold_recv = 1'b0;

  function automatic rsp_t predict_alloc(logic [3:0] want);
    rsp_t r;
    int best, best_ord;
    bit found;
    r = '{ST_OK, 32'd0, 4'd0};
    found = 0;
    best = 0;
    best_ord = 0;
    if (want > MaxOrderDef) begin
      r.st = ST_ORDER;
      return r;
    end
    for (int i = 0; i < NPages; i++)
      if (pg_head[i] && pg_ord[i] >= want && (!found || pg_ord[i] < best_ord)) begin
        found = 1;
        best = i;
        best_ord = pg_ord[i];
      end
    if (!found) begin
      r.st = ST_NOMEM;
      return r;
    end
    pg_head[best] = 1'b0;
    while (best_ord > want) begin
      best_ord--;
      pg_head[best] = 1'b1;
      pg_used[best] = 1'b0;
      pg_ord[best] = best_ord[3:0];
      best += 1 << best_ord;
    end
    pg_head[best] = 1'b0;
    pg_used[best] = 1'b1;
    pg_ord[best] = want;
    r.page = base_page + 32'(best);
    r.ord = want;
    return r;
  endfunction

  function automatic rsp_t predict_free(logic [31:0] page);
    rsp_t r;
    logic [31:0] idx;
    int ix, bud, tmp, o;
    r = '{ST_OK, 32'd0, 4'd0};
    idx = page - base_page;
    if (idx >= NPages) begin
      r.st = ST_RANGE;
      return r;
    end
    ix = int'(idx);
    if (!pg_used[ix]) begin
      r.st = ST_DOUBLE;
      return r;
    end
    o = pg_ord[ix];
    pg_used[ix] = 1'b0;
    pg_head[ix] = 1'b1;
    while (o < MaxOrderDef) begin
      bud = ix ^ (1 << o);
      if (!pg_head[bud] || pg_ord[bud] != o) break;
      if (bud < ix) begin
        tmp = ix;
        ix = bud;
        bud = tmp;
      end
      pg_head[bud] = 1'b0;
      pg_used[bud] = 1'b0;
      pg_ord[bud] = 4'd0;
      o++;
      pg_head[ix] = 1'b1;
      pg_used[ix] = 1'b0;
      pg_ord[ix] = o[3:0];
    end
    r.page = base_page + 32'(ix);
    r.ord = o[3:0];
    return r;
  endfunction

  function automatic rsp_t predict_request(logic rtype, logic [3:0] ord, logic [31:0] page);
    return (rtype == REQ_ALLOC) ? predict_alloc(ord) : predict_free(page);
  endfunction

  // random page: mostly managed pages, some out of range or wrapping
  function automatic logic [31:0] pick_page();
    int k;
    k = $urandom_range(99);
    if (k < 85) return base_page + $urandom_range(NPages - 1);
    if (k < 90) return base_page + NPages + $urandom_range(3);
    if (k < 95) return base_page - 1 - $urandom_range(3);
    return $urandom;
  endfunction

  // valid stays high after a transfer until the next item or wait_drained
  task automatic send_item(logic rtype, logic [3:0] ord, logic [31:0] page,
                           logic fixed, status_t x_st, logic [31:0] x_page,
                           logic [3:0] x_ord);
    rsp_t r;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= rtype;
    in_ch.req_order <= ord;
    in_ch.page_number <= page;
    do @(posedge clk); while (!in_ch.ready);
    r = predict_request(rtype, ord, page);
    if (fixed && (r.st != x_st || r.page != x_page || r.ord != x_ord))
      $display("%0t table row disagrees with predictor: st %0d page %0h ord %0d",
               $time, x_st, x_page, x_ord);
    if (fixed) r = '{x_st, x_page, x_ord};
    pending_rsp.push_back(r);
    n_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_base(logic [31:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.mem_base_page <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    base_page = v;
  endtask

  task automatic random_phase(int n, int s_idle, int r_stall);
    int k;
    logic [3:0] o;
    send_idle = s_idle;
    recv_stall = r_stall;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 45) begin
        o = ($urandom_range(9) < 8) ? 4'($urandom_range(4)) : 4'($urandom_range(15));
        send_item(REQ_ALLOC, o, $urandom, 1'b0, ST_OK, 32'd0, 4'd0);
      end else begin
        send_item(REQ_FREE, 4'($urandom), pick_page(), 1'b0, ST_OK, 32'd0, 4'd0);
      end
    end
    wait_drained();
  endtask

  // result side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !hold_recv && !(recv_stall > 0 && $urandom_range(99) < recv_stall);
      if (out_ch.valid && out_ch.ready) begin
        n_got++;
        if (pending_rsp.size() == 0) begin
          errors++;
          $display("%0t unexpected result: st %0d page %0h ord %0d", $time,
                   out_ch.status, out_ch.page_out, out_ch.block_order);
        end else begin
          rsp_t e;
          e = pending_rsp.pop_front();
          if (out_ch.status != e.st || out_ch.page_out != e.page ||
              out_ch.block_order != e.ord) begin
            errors++;
            $display("%0t mismatch: expected st %0d page %0h ord %0d,",
                     $time, e.st, e.page, e.ord,
                     " got st %0d page %0h ord %0d",
                     out_ch.status, out_ch.page_out, out_ch.block_order);
          end
          if (e.st != ST_OK) n_err++;
          else n_ok++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic add_row(logic rtype, logic [3:0] ord, logic [31:0] page,
                         logic fixed, status_t st, logic [31:0] xp, logic [3:0] xo);
    row_t r;
    r = '{rtype, ord, page, fixed, st, xp, xo};
    dir_rows.push_back(r);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_ALLOC;
    in_ch.req_order = 4'd0;
    in_ch.page_number = 32'd0;
    cfg_ch.valid = 1'b0;
    cfg_ch.mem_base_page = 32'd0;
    base_page = BasePageRst;
    for (int i = 0; i < NPages; i++) begin
      pg_used[i] = 1'b1;
      pg_head[i] = 1'b0;
      pg_ord[i] = 4'd0;
    end

    // after reset nothing is free
    add_row(REQ_ALLOC, 4'd0, 32'd0, 1, ST_NOMEM, 0, 0);
    add_row(REQ_ALLOC, 4'd15, 32'hFFFF_FFFF, 1, ST_ORDER, 0, 0);
    add_row(REQ_ALLOC, 4'd11, 32'd0, 1, ST_ORDER, 0, 0);
    add_row(REQ_FREE, 4'd15, 32'd0, 1, ST_RANGE, 0, 0);
    add_row(REQ_FREE, 4'd0, 32'hFFFF_FFFF, 1, ST_RANGE, 0, 0);
    add_row(REQ_FREE, 4'd0, BasePageRst + NPages, 1, ST_RANGE, 0, 0);
    add_row(REQ_FREE, 4'd0, BasePageRst - 1, 1, ST_RANGE, 0, 0);
    add_row(REQ_FREE, 4'd0, BasePageRst, 1, ST_OK, BasePageRst, 4'd0);
    add_row(REQ_FREE, 4'd0, BasePageRst, 1, ST_DOUBLE, 0, 0);
    add_row(REQ_FREE, 4'd0, BasePageRst + 1, 1, ST_OK, BasePageRst, 4'd1);
    add_row(REQ_FREE, 4'd0, BasePageRst + 1, 1, ST_DOUBLE, 0, 0);
    add_row(REQ_FREE, 4'd0, BasePageRst + NPages - 1, 0, ST_OK, 0, 0);
    add_row(REQ_ALLOC, 4'd1, 32'd0, 0, ST_OK, 0, 0);
    add_row(REQ_ALLOC, 4'd0, 32'd0, 0, ST_OK, 0, 0);
    add_row(REQ_ALLOC, 4'd10, 32'd0, 1, ST_NOMEM, 0, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].rtype, dir_rows[i].ord, dir_rows[i].page, dir_rows[i].fixed,
                dir_rows[i].x_st, dir_rows[i].x_page, dir_rows[i].x_ord);
    wait_drained();

    // fill the pool page by page: the last free merges into one order-10 block
    for (int i = 0; i < NPages; i++) begin
      send_idle = 0;
      if (pg_used[i]) send_item(REQ_FREE, 4'd0, base_page + i, 1'b0, ST_OK, 32'd0, 4'd0);
    end
    wait_drained();
    send_item(REQ_ALLOC, 4'd10, 32'd0, 1'b1, ST_OK, base_page, 4'd10);
    send_item(REQ_FREE, 4'd0, base_page, 1'b1, ST_OK, base_page, 4'd10);
    wait_drained();

    random_phase(200, 0, 0);
    // receiver holds off while the sender keeps offering
    fork
      begin
        hold_recv = 1'b1;
        repeat (300) @(posedge clk);
        hold_recv = 1'b0;
      end
      random_phase(20, 0, 0);
    join
    write_base(32'hFFFF_FFF0);     // managed range wraps past zero
    random_phase(120, 47, 0);
    write_base(32'h0000_0000);
    random_phase(120, 0, 47);
    write_base(32'hFFFF_FFFF);
    random_phase(120, 35, 35);
    write_base(BasePageRst);
    random_phase(120, 0, 0);
    write_base(32'h1234_5678);
    random_phase(120, 47, 47);

    repeat (20) @(posedge clk);
    $display("Sent %0d requests, %0d results checked (%0d successful, %0d errors)",
             n_sent, n_got, n_ok, n_err);
    $display("Covered fill/drain, splits and merges, error codes, wrapped bases, stalls");
    if (errors == 0 && pending_rsp.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/bpa_pkg.sv
rtl/bpa_if.sv
rtl/bpa_ram.sv
rtl/buddy_page_allocator.sv
test/testbench.sv
